@@ rtl/mwo_pkg.sv @@
// Shared types, constants and helper functions of the multi-waveform oscillator.
`timescale 1ns / 1ps

package mwo_pkg;

    localparam int TICK_W      = 32;
    localparam int FREQ_W      = 15;
    localparam int WAVE_W      = 2;
    localparam int SAMPLE_W    = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 15;
    localparam int REM_W       = 14;
    localparam int U_W         = 18;
    localparam int F_W         = 17;
    localparam int Q_W         = 31;

    localparam int PHASE_BITS_DEF       = 12;
    localparam int SINE_TABLE_DEPTH_DEF = 256;

    localparam logic [FREQ_W-1:0] FREQ_RESET    = 15'd100;
    localparam logic [REM_W-1:0]  TICKS_PER_SEC = 14'd10000;
    localparam logic [63:0]       RECIP_45      = 64'd3518437209;

    localparam logic [Q_W-1:0] Q30_ONE = 31'd1073741824;
    localparam logic [Q_W-1:0] SIN_C1  = 31'd1686629713;
    localparam logic [Q_W-1:0] SIN_C3  = 31'd693598669;
    localparam logic [Q_W-1:0] SIN_C5  = 31'd85569306;
    localparam logic [Q_W-1:0] SIN_C7  = 31'd5026994;
    localparam logic [Q_W-1:0] SIN_C9  = 31'd172272;

    localparam logic [CFG_IDX_W-1:0] CFG_FREQ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE = 2'd1;

    localparam logic [SAMPLE_W-1:0] DAC_MAX = 10'd1023;
    localparam logic [SAMPLE_W-1:0] DAC_MID = 10'd512;

    typedef enum logic [WAVE_W-1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SQUARE   = 2'd1,
        WAVE_SAWTOOTH = 2'd2,
        WAVE_TRIANGLE = 2'd3
    } t_wave;

    typedef struct packed {
        logic [U_W-1:0]      u;
        logic [SAMPLE_W-1:0] saw;
    } t_phase;

    typedef struct packed {
        logic [Q_W-1:0]      s;
        logic [F_W-1:0]      f;
        logic                neg;
        logic [SAMPLE_W-1:0] saw;
    } t_sine;

    function automatic logic [Q_W-1:0] horner_step(
        input logic [Q_W-1:0] c,
        input logic [Q_W-1:0] x2,
        input logic [Q_W-1:0] t
    );
        logic [61:0] m;
        logic [31:0] d;
        m = 62'(x2) * 62'(t);
        d = 32'(c) - m[61:30];
        return d[Q_W-1:0];
    endfunction

    function automatic logic [SAMPLE_W-1:0] to_dac(
        input logic [SAMPLE_W-1:0] whole,
        input logic                frac,
        input logic                neg
    );
        logic [SAMPLE_W:0] sum;
        logic [SAMPLE_W:0] diff;
        logic [SAMPLE_W-1:0] v;
        if (neg) begin
            sum  = 11'(whole) + 11'(frac);
            diff = 11'(DAC_MID) - sum;
            v    = (sum >= 11'(DAC_MID)) ? '0 : diff[SAMPLE_W-1:0];
        end else begin
            sum = 11'(DAC_MID) + 11'(whole);
            v   = (sum > 11'(DAC_MAX)) ? DAC_MAX : sum[SAMPLE_W-1:0];
        end
        return v;
    endfunction

endpackage

@@ rtl/mwo_tick_if.sv @@
// Valid/ready channel that carries one tick beat.
`timescale 1ns / 1ps

interface mwo_tick_if;
    import mwo_pkg::*;

    logic              valid;
    logic              ready;
    logic [TICK_W-1:0] tick;

    modport source(output valid, output tick, input ready);
    modport sink(input valid, input tick, output ready);
endinterface

@@ rtl/mwo_sample_if.sv @@
// Valid/ready channel that carries one DAC sample beat.
`timescale 1ns / 1ps

interface mwo_sample_if;
    import mwo_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source(output valid, output sample, input ready);
    modport sink(input valid, input sample, output ready);
endinterface

@@ rtl/mwo_phase.sv @@
// Phase pipeline: tick times frequency modulo one second, truncated phase and table position.
`timescale 1ns / 1ps

module mwo_phase #(
    parameter int PHASE_BITS       = mwo_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = mwo_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [mwo_pkg::TICK_W-1:0] i_tick,
    input  logic [mwo_pkg::FREQ_W-1:0] i_freq,
    output logic                      o_valid,
    input  logic                      i_ready,
    output mwo_pkg::t_phase           o_phase
);
    import mwo_pkg::*;

    localparam int NS     = 8;
    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int IDXP_W = PHASE_BITS + IDX_W + 1;
    localparam int UP_W   = IDX_W + 44;
    localparam logic [43:0] U_RECIP = 44'(((64'd1 << 42) + 64'(SINE_TABLE_DEPTH) - 64'd1)
                                          / 64'(SINE_TABLE_DEPTH));

    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS-1:0] vin;
    logic [NS:0]   en;

    logic [TICK_W-1:0]     r_tick1;
    logic [18:0]           r_q1;
    logic [REM_W-1:0]      r_r1;
    logic [28:0]           r_prod;
    logic [28:0]           r_prod4;
    logic [15:0]           r_q2;
    logic [REM_W-1:0]      r_p;
    logic [PHASE_BITS-1:0] r_ph;
    logic [IDX_W-1:0]      r_idx;
    logic [SAMPLE_W-1:0]   r_saw7;
    logic [U_W-1:0]        r_u;
    logic [SAMPLE_W-1:0]   r_saw8;

    logic [63:0]                q1_prod;
    logic [32:0]                r1_full;
    logic [28:0]                prod;
    logic [63:0]                q2_prod;
    logic [29:0]                p_full;
    logic [63:0]                ph_prod;
    logic [IDXP_W-1:0]          idx_prod;
    logic [PHASE_BITS+9:0]      saw_full;
    logic [UP_W-1:0]            u_prod;

    assign vin = {r_vld[NS-2:0], i_valid};

    always_comb begin
        en[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        for (int k = 0; k < NS; k++) begin
            n_vld[k] = en[k] ? vin[k] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign q1_prod  = 64'(i_tick) * RECIP_45;
    assign r1_full  = 33'(r_tick1) - 33'(r_q1) * 33'(TICKS_PER_SEC);
    assign prod     = 29'(r_r1) * 29'(i_freq);
    assign q2_prod  = 64'(r_prod) * RECIP_45;
    assign p_full   = 30'(r_prod4) - 30'(r_q2) * 30'(TICKS_PER_SEC);
    assign ph_prod  = (64'(r_p) << PHASE_BITS) * RECIP_45;
    assign idx_prod = IDXP_W'(r_ph) * IDXP_W'(SINE_TABLE_DEPTH);
    assign saw_full = {r_ph, 10'b0};
    assign u_prod   = UP_W'(r_idx) * UP_W'(U_RECIP);

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_tick1 <= i_tick;
            r_q1    <= q1_prod[45 +: 19];
        end
        if (en[1]) begin
            r_r1 <= r1_full[REM_W-1:0];
        end
        if (en[2]) begin
            r_prod <= prod;
        end
        if (en[3]) begin
            r_prod4 <= r_prod;
            r_q2    <= q2_prod[45 +: 16];
        end
        if (en[4]) begin
            r_p <= p_full[REM_W-1:0];
        end
        if (en[5]) begin
            r_ph <= ph_prod[45 +: PHASE_BITS];
        end
        if (en[6]) begin
            r_idx  <= idx_prod[PHASE_BITS +: IDX_W];
            r_saw7 <= saw_full[PHASE_BITS +: SAMPLE_W];
        end
        if (en[7]) begin
            r_u    <= u_prod[24 +: U_W];
            r_saw8 <= r_saw7;
        end
    end

    assign o_ready     = en[0];
    assign o_valid     = r_vld[NS-1];
    assign o_phase.u   = r_u;
    assign o_phase.saw = r_saw8;

endmodule

@@ rtl/mwo_sine.sv @@
// Quarter-wave sine pipeline: folding, x squared and the polynomial evaluated in Q30.
`timescale 1ns / 1ps

module mwo_sine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  mwo_pkg::t_phase i_phase,
    output logic            o_valid,
    input  logic            i_ready,
    output mwo_pkg::t_sine  o_sine
);
    import mwo_pkg::*;

    localparam int NS = 6;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS-1:0] vin;
    logic [NS:0]   en;

    logic [F_W-1:0]      r_f   [NS];
    logic                r_neg [NS];
    logic [SAMPLE_W-1:0] r_saw [NS];
    logic [Q_W-1:0]      r_x2  [NS-2];
    logic [Q_W-1:0]      r_t   [1:NS-2];
    logic [Q_W-1:0]      r_s;

    logic [1:0]     quad;
    logic [F_W-1:0] f0;
    logic [F_W-1:0] f_fold;
    logic [Q_W-1:0] x_in;
    logic [61:0]    xx;
    logic [Q_W-1:0] x_last;
    logic [61:0]    xs;
    logic [31:0]    s_raw;

    assign vin = {r_vld[NS-2:0], i_valid};

    always_comb begin
        en[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        for (int k = 0; k < NS; k++) begin
            n_vld[k] = en[k] ? vin[k] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign quad   = i_phase.u[U_W-1:U_W-2];
    assign f0     = {1'b0, i_phase.u[15:0]};
    assign f_fold = quad[0] ? (17'h10000 - f0) : f0;
    assign x_in   = {f_fold, 14'b0};
    assign xx     = 62'(x_in) * 62'(x_in);
    assign x_last = {r_f[NS-2], 14'b0};
    assign xs     = 62'(x_last) * 62'(r_t[NS-2]);
    assign s_raw  = xs[61:30];

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_f[0]   <= f_fold;
            r_neg[0] <= quad[1];
            r_saw[0] <= i_phase.saw;
            r_x2[0]  <= xx[60:30];
        end
        for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
                r_f[k]   <= r_f[k-1];
                r_neg[k] <= r_neg[k-1];
                r_saw[k] <= r_saw[k-1];
            end
        end
        for (int k = 1; k < NS - 2; k++) begin
            if (en[k]) begin
                r_x2[k] <= r_x2[k-1];
            end
        end
        if (en[1]) begin
            r_t[1] <= horner_step(SIN_C7, r_x2[0], SIN_C9);
        end
        if (en[2]) begin
            r_t[2] <= horner_step(SIN_C5, r_x2[1], r_t[1]);
        end
        if (en[3]) begin
            r_t[3] <= horner_step(SIN_C3, r_x2[2], r_t[2]);
        end
        if (en[4]) begin
            r_t[4] <= horner_step(SIN_C1, r_x2[3], r_t[3]);
        end
        if (en[5]) begin
            r_s <= (s_raw > 32'(Q30_ONE)) ? Q30_ONE : s_raw[Q_W-1:0];
        end
    end

    assign o_ready    = en[0];
    assign o_valid    = r_vld[NS-1];
    assign o_sine.s   = r_s;
    assign o_sine.f   = r_f[NS-1];
    assign o_sine.neg = r_neg[NS-1];
    assign o_sine.saw = r_saw[NS-1];

endmodule

@@ rtl/mwo_shape.sv @@
// Output stage: DAC scaling of sine and triangle, waveform select and the output register.
`timescale 1ns / 1ps

module mwo_shape (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  mwo_pkg::t_sine              i_sine,
    input  mwo_pkg::t_wave              i_wave,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [mwo_pkg::SAMPLE_W-1:0] o_sample
);
    import mwo_pkg::*;

    logic                r_vld;
    logic                n_vld;
    logic [SAMPLE_W-1:0] r_sample;
    logic [SAMPLE_W-1:0] n_sample;
    logic                en;
    logic [SAMPLE_W-1:0] sine;
    logic [SAMPLE_W-1:0] tri_wave;

    assign en       = !r_vld || i_ready;
    assign n_vld    = en ? i_valid : r_vld;
    assign sine     = to_dac(i_sine.s[30:21], |i_sine.s[20:0], i_sine.neg);
    assign tri_wave = to_dac(i_sine.f[16:7], |i_sine.f[6:0], i_sine.neg);

    always_comb begin
        case (i_wave)
            WAVE_SINE: begin
                n_sample = sine;
            end
            WAVE_SQUARE: begin
                n_sample = (sine > DAC_MID) ? DAC_MAX : '0;
            end
            WAVE_SAWTOOTH: begin
                n_sample = i_sine.saw;
            end
            default: begin
                n_sample = tri_wave;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sample <= n_sample;
        end
    end

    assign o_ready  = en;
    assign o_valid  = r_vld;
    assign o_sample = r_sample;

endmodule

@@ rtl/multi_waveform_oscillator.sv @@
// Top level of the multi-waveform oscillator: configuration registers and the sample pipeline.
//
// Each tick beat on i_tick (time in 100 us units) yields one 10-bit DAC sample beat on
// o_sample, in input order. The phase is frac(tick * frequency / 10000 Hz), truncated to
// PHASE_BITS bits and placed on a table grid of SINE_TABLE_DEPTH points for sine and
// triangle. The waveform register selects sine, square, sawtooth or triangle.
// Configuration: write i_cfg_wdata to register i_cfg_idx when i_cfg_we is high
// (0 frequency in Hz, 1 waveform); write only while no beats are in flight.
// From tick acceptance to sample valid a beat passes eight phase stages,
// six quarter-sine polynomial stages and the output register.
// One beat per cycle unless the output stalls; each phase and sine stage holds one multiplier.
// Reset clears all valid bits and sets 100 Hz and sine.
// When the receiver stalls, the output register holds its sample and stages fill
// up behind it; ready falls only when every stage is occupied.
`timescale 1ns / 1ps

module multi_waveform_oscillator #(
    parameter int PHASE_BITS       = mwo_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = mwo_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mwo_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mwo_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    mwo_tick_if.sink                       i_tick,
    mwo_sample_if.source                   o_sample
);
    import mwo_pkg::*;

    logic [FREQ_W-1:0] r_freq;
    t_wave             r_wave;

    logic   ph_valid;
    logic   ph_ready;
    t_phase ph_data;
    logic   sn_valid;
    logic   sn_ready;
    t_sine  sn_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq <= FREQ_RESET;
            r_wave <= WAVE_SINE;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_FREQ) begin
                r_freq <= i_cfg_wdata[FREQ_W-1:0];
            end else if (i_cfg_idx == CFG_WAVE) begin
                r_wave <= t_wave'(i_cfg_wdata[WAVE_W-1:0]);
            end
        end
    end

    mwo_phase #(
        .PHASE_BITS       (PHASE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_tick.valid),
        .o_ready (i_tick.ready),
        .i_tick  (i_tick.tick),
        .i_freq  (r_freq),
        .o_valid (ph_valid),
        .i_ready (ph_ready),
        .o_phase (ph_data)
    );

    mwo_sine u_sine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ph_valid),
        .o_ready (ph_ready),
        .i_phase (ph_data),
        .o_valid (sn_valid),
        .i_ready (sn_ready),
        .o_sine  (sn_data)
    );

    mwo_shape u_shape (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (sn_valid),
        .o_ready  (sn_ready),
        .i_sine   (sn_data),
        .i_wave   (r_wave),
        .o_valid  (o_sample.valid),
        .i_ready  (o_sample.ready),
        .o_sample (o_sample.sample)
    );

`ifndef SYNTHESIS
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_sample.valid)
        else $error("Output beat valid right after reset.");

    a_empty_output_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_sample.valid |-> i_tick.ready)
        else $error("Input not ready although the output register is empty.");

    a_stall_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !sn_valid |-> ph_ready)
        else $error("Sine stages refuse a beat while their last stage is empty.");
`endif

endmodule
